/* hw/rtl/triangle_isoline_segment_top_defines.svh */
// Assertion macros shared by the triangle isoline segment RTL.
`ifndef TRIANGLE_ISOLINE_SEGMENT_TOP_DEFINES_SVH
`define TRIANGLE_ISOLINE_SEGMENT_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tis_pkg.sv */
// Shared types and constants of the triangle isoline segment pipeline.
package tis_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned EpsW     = 16;
  localparam int unsigned DiffW    = CoordW + 1;
  localparam int unsigned RemW     = DiffW + 1;
  localparam int unsigned MuW      = 17;
  localparam int unsigned FracW    = 16;
  localparam int unsigned ProdW    = DiffW + MuW;
  localparam int unsigned DivSteps = MuW;
  localparam int unsigned FrontStg = 2;
  localparam int unsigned LerpStg  = 2;
  localparam int unsigned TailStg  = DivSteps + LerpStg;
  localparam int unsigned TotalStg = FrontStg + TailStg;

  localparam logic [1:0] CfgIso = 2'd0;
  localparam logic [1:0] CfgEps = 2'd1;

  // One crossing while its ratio is being divided out.
  typedef struct packed {
    logic [RemW-1:0]          rem;
    logic [DiffW-1:0]         den;
    logic [MuW-1:0]           quo;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic [DiffW-1:0]         dmx;
    logic [DiffW-1:0]         dmy;
    logic                     sx;
    logic                     sy;
  } div_lane_t;

  // One crossing after the ratio has been applied to the edge deltas.
  typedef struct packed {
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic [ProdW-1:0]         px;
    logic [ProdW-1:0]         py;
    logic                     sx;
    logic                     sy;
  } mul_lane_t;

endpackage

/* hw/rtl/tis_front.sv */
// Edge selection and crossing set-up: two register stages.
module tis_front (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [tis_pkg::CoordW-1:0]  iso_i,
  input  logic [tis_pkg::EpsW-1:0]           eps_i,
  input  logic signed [tis_pkg::CoordW-1:0]  x0_i,
  input  logic signed [tis_pkg::CoordW-1:0]  y0_i,
  input  logic signed [tis_pkg::CoordW-1:0]  v0_i,
  input  logic signed [tis_pkg::CoordW-1:0]  x1_i,
  input  logic signed [tis_pkg::CoordW-1:0]  y1_i,
  input  logic signed [tis_pkg::CoordW-1:0]  v1_i,
  input  logic signed [tis_pkg::CoordW-1:0]  x2_i,
  input  logic signed [tis_pkg::CoordW-1:0]  y2_i,
  input  logic signed [tis_pkg::CoordW-1:0]  v2_i,
  output tis_pkg::div_lane_t                 lane_a_o,
  output tis_pkg::div_lane_t                 lane_b_o,
  output logic                               has_o
);

  typedef logic signed [tis_pkg::CoordW-1:0] coord_t;

  coord_t ax0_q, ay0_q, av0_q, ax1_q, ay1_q, av1_q;
  coord_t bx0_q, by0_q, bv0_q, bx1_q, by1_q, bv1_q;
  coord_t ax0_d, ay0_d, av0_d, ax1_d, ay1_d, av1_d;
  coord_t bx0_d, by0_d, bv0_d, bx1_d, by1_d, bv1_d;
  logic   has1_q, has1_d, has2_q;
  logic   lo0, lo1, lo2, c01, c12;
  tis_pkg::div_lane_t lane_a_q, lane_b_q;

  function automatic logic [tis_pkg::DiffW-1:0] mag33(
    input logic signed [tis_pkg::DiffW-1:0] v
  );
    mag33 = v[tis_pkg::DiffW-1] ? -v : v;
  endfunction

  function automatic tis_pkg::div_lane_t prep(
    input coord_t px, input coord_t py, input coord_t pv,
    input coord_t qx, input coord_t qy, input coord_t qv,
    input coord_t iso, input logic [tis_pkg::EpsW-1:0] eps,
    input logic has
  );
    logic signed [tis_pkg::DiffW-1:0] num, den, niq, dx, dy;
    logic [tis_pkg::DiffW-1:0] nm, dm, eps_w;
    logic near_p, near_q, flat;
    tis_pkg::div_lane_t l;
    num    = tis_pkg::DiffW'(iso) - tis_pkg::DiffW'(pv);
    den    = tis_pkg::DiffW'(qv) - tis_pkg::DiffW'(pv);
    niq    = tis_pkg::DiffW'(iso) - tis_pkg::DiffW'(qv);
    dx     = tis_pkg::DiffW'(qx) - tis_pkg::DiffW'(px);
    dy     = tis_pkg::DiffW'(qy) - tis_pkg::DiffW'(py);
    nm     = mag33(num);
    dm     = mag33(den);
    eps_w  = tis_pkg::DiffW'(eps);
    near_p = nm < eps_w;
    near_q = mag33(niq) < eps_w;
    flat   = dm < eps_w;
    l.rem  = {1'b0, nm};
    l.den  = dm;
    l.quo  = '0;
    l.bx   = px;
    l.by   = py;
    l.dmx  = mag33(dx);
    l.dmy  = mag33(dy);
    l.sx   = dx[tis_pkg::DiffW-1];
    l.sy   = dy[tis_pkg::DiffW-1];
    // End points and flat edges take a vertex as it stands, no interpolation.
    if (!has) begin
      l.bx = '0;
      l.by = '0;
    end else if (near_q && !near_p) begin
      l.bx = qx;
      l.by = qy;
    end
    if (!has || near_p || near_q || flat) begin
      l.dmx = '0;
      l.dmy = '0;
    end
    prep = l;
  endfunction

  always_comb begin
    lo0    = v0_i < iso_i;
    lo1    = v1_i < iso_i;
    lo2    = v2_i < iso_i;
    c01    = lo0 ^ lo1;
    c12    = lo1 ^ lo2;
    has1_d = c01 | c12;
    if (c01) begin
      {ax0_d, ay0_d, av0_d, ax1_d, ay1_d, av1_d} = {x0_i, y0_i, v0_i, x1_i, y1_i, v1_i};
    end else begin
      {ax0_d, ay0_d, av0_d, ax1_d, ay1_d, av1_d} = {x1_i, y1_i, v1_i, x2_i, y2_i, v2_i};
    end
    if (c01 && c12) begin
      {bx0_d, by0_d, bv0_d, bx1_d, by1_d, bv1_d} = {x1_i, y1_i, v1_i, x2_i, y2_i, v2_i};
    end else begin
      {bx0_d, by0_d, bv0_d, bx1_d, by1_d, bv1_d} = {x2_i, y2_i, v2_i, x0_i, y0_i, v0_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      {ax0_q, ay0_q, av0_q, ax1_q, ay1_q, av1_q} <= {ax0_d, ay0_d, av0_d, ax1_d, ay1_d, av1_d};
      {bx0_q, by0_q, bv0_q, bx1_q, by1_q, bv1_q} <= {bx0_d, by0_d, bv0_d, bx1_d, by1_d, bv1_d};
      has1_q   <= has1_d;
      has2_q   <= has1_q;
      lane_a_q <= prep(ax0_q, ay0_q, av0_q, ax1_q, ay1_q, av1_q, iso_i, eps_i, has1_q);
      lane_b_q <= prep(bx0_q, by0_q, bv0_q, bx1_q, by1_q, bv1_q, iso_i, eps_i, has1_q);
    end
  end

  assign lane_a_o = lane_a_q;
  assign lane_b_o = lane_b_q;
  assign has_o    = has2_q;

endmodule

/* hw/rtl/tis_div_step.sv */
// One restoring division step: one ratio bit per register stage.
module tis_div_step (
  input  logic               clk_i,
  input  logic               en_i,
  input  tis_pkg::div_lane_t lane_i,
  output tis_pkg::div_lane_t lane_o
);

  tis_pkg::div_lane_t lane_d, lane_q;
  logic [tis_pkg::RemW-1:0] diff;
  logic                     take;

  always_comb begin
    diff   = lane_i.rem - {1'b0, lane_i.den};
    take   = lane_i.rem >= {1'b0, lane_i.den};
    lane_d = lane_i;
    lane_d.quo = {lane_i.quo[tis_pkg::MuW-2:0], take};
    lane_d.rem = take ? {diff[tis_pkg::RemW-2:0], 1'b0} : {lane_i.rem[tis_pkg::RemW-2:0], 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

/* hw/rtl/tis_divider.sv */
// Pipelined ratio divider for both crossings of a triangle.
module tis_divider (
  input  logic               clk_i,
  input  logic               en_i,
  input  tis_pkg::div_lane_t lane_a_i,
  input  tis_pkg::div_lane_t lane_b_i,
  output tis_pkg::div_lane_t lane_a_o,
  output tis_pkg::div_lane_t lane_b_o
);

  tis_pkg::div_lane_t ca [tis_pkg::DivSteps+1];
  tis_pkg::div_lane_t cb [tis_pkg::DivSteps+1];

  assign ca[0] = lane_a_i;
  assign cb[0] = lane_b_i;

  for (genvar s = 0; s < tis_pkg::DivSteps; s++) begin : g_step
    tis_div_step u_a (.clk_i, .en_i, .lane_i(ca[s]), .lane_o(ca[s+1]));
    tis_div_step u_b (.clk_i, .en_i, .lane_i(cb[s]), .lane_o(cb[s+1]));
  end

  assign lane_a_o = ca[tis_pkg::DivSteps];
  assign lane_b_o = cb[tis_pkg::DivSteps];

endmodule

/* hw/rtl/tis_lerp.sv */
// Scales the edge deltas by the ratio and adds them to the base point.
module tis_lerp (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  tis_pkg::div_lane_t                 lane_i,
  output logic signed [tis_pkg::CoordW-1:0]  rx_o,
  output logic signed [tis_pkg::CoordW-1:0]  ry_o
);

  tis_pkg::mul_lane_t m_q, m_d;
  logic signed [tis_pkg::CoordW-1:0] rx_q, ry_q;
  logic [tis_pkg::DiffW-1:0] ox, oy;
  logic [tis_pkg::DiffW:0]   bxw, byw, sx, sy;

  always_comb begin
    m_d.bx = lane_i.bx;
    m_d.by = lane_i.by;
    m_d.sx = lane_i.sx;
    m_d.sy = lane_i.sy;
    m_d.px = tis_pkg::ProdW'(lane_i.dmx) * tis_pkg::ProdW'(lane_i.quo);
    m_d.py = tis_pkg::ProdW'(lane_i.dmy) * tis_pkg::ProdW'(lane_i.quo);
    ox  = m_q.px[tis_pkg::ProdW-2:tis_pkg::FracW];
    oy  = m_q.py[tis_pkg::ProdW-2:tis_pkg::FracW];
    bxw = (tis_pkg::DiffW+1)'(m_q.bx);
    byw = (tis_pkg::DiffW+1)'(m_q.by);
    sx  = m_q.sx ? bxw - {1'b0, ox} : bxw + {1'b0, ox};
    sy  = m_q.sy ? byw - {1'b0, oy} : byw + {1'b0, oy};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q  <= m_d;
      rx_q <= sx[tis_pkg::CoordW-1:0];
      ry_q <= sy[tis_pkg::CoordW-1:0];
    end
  end

  assign rx_o = rx_q;
  assign ry_o = ry_q;

endmodule

/* hw/rtl/triangle_isoline_segment_top.sv */
// Throughput: one triangle per cycle while no result is stalled at the output;
// two front stages, seventeen divider stages (one ratio bit each) and a
// multiply stage and an add stage.
// A stall while a result waits at the output freezes the whole pipeline.
// Reset (rst_ni low, asynchronous) clears the valid bits and sets iso_q
// (the iso level) to 0 and eps_q (the tie epsilon) to 1.
module triangle_isoline_segment_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [1:0]                         cfg_index_i,
  input  logic [tis_pkg::CoordW-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [tis_pkg::CoordW-1:0]  x0_i,
  input  logic signed [tis_pkg::CoordW-1:0]  y0_i,
  input  logic signed [tis_pkg::CoordW-1:0]  v0_i,
  input  logic signed [tis_pkg::CoordW-1:0]  x1_i,
  input  logic signed [tis_pkg::CoordW-1:0]  y1_i,
  input  logic signed [tis_pkg::CoordW-1:0]  v1_i,
  input  logic signed [tis_pkg::CoordW-1:0]  x2_i,
  input  logic signed [tis_pkg::CoordW-1:0]  y2_i,
  input  logic signed [tis_pkg::CoordW-1:0]  v2_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               has_segment_o,
  output logic signed [tis_pkg::CoordW-1:0]  ax_o,
  output logic signed [tis_pkg::CoordW-1:0]  ay_o,
  output logic signed [tis_pkg::CoordW-1:0]  bx_o,
  output logic signed [tis_pkg::CoordW-1:0]  by_o
);

`include "triangle_isoline_segment_top_defines.svh"

  logic signed [tis_pkg::CoordW-1:0] iso_q;
  logic [tis_pkg::EpsW-1:0]          eps_q;
  logic [tis_pkg::TotalStg-1:0]      vld_q;
  logic [tis_pkg::TailStg-1:0]       has_q;
  logic                              en;
  logic                              has_f;
  tis_pkg::div_lane_t                fa, fb, da, db;

  // The pipeline moves as one; it holds only while a finished result is stalled.
  assign en          = !(vld_q[tis_pkg::TotalStg-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  // Configuration writes: indices beyond the register list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iso_q <= '0;
      eps_q <= tis_pkg::EpsW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tis_pkg::CfgIso: iso_q <= cfg_data_i;
        tis_pkg::CfgEps: eps_q <= cfg_data_i[tis_pkg::EpsW-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits travel alongside the data, one per register stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[tis_pkg::TotalStg-2:0], in_valid_i};
    end
  end

  // The segment flag is known after the front stages and then only delayed.
  always_ff @(posedge clk_i) begin
    if (en) begin
      has_q <= {has_q[tis_pkg::TailStg-2:0], has_f};
    end
  end

  tis_front u_front (
    .clk_i, .en_i(en), .iso_i(iso_q), .eps_i(eps_q),
    .x0_i, .y0_i, .v0_i, .x1_i, .y1_i, .v1_i, .x2_i, .y2_i, .v2_i,
    .lane_a_o(fa), .lane_b_o(fb), .has_o(has_f)
  );

  tis_divider u_div (
    .clk_i, .en_i(en), .lane_a_i(fa), .lane_b_i(fb), .lane_a_o(da), .lane_b_o(db)
  );

  tis_lerp u_lerp_a (.clk_i, .en_i(en), .lane_i(da), .rx_o(ax_o), .ry_o(ay_o));
  tis_lerp u_lerp_b (.clk_i, .en_i(en), .lane_i(db), .rx_o(bx_o), .ry_o(by_o));

  assign out_valid_o   = vld_q[tis_pkg::TotalStg-1];
  assign has_segment_o = has_q[tis_pkg::TailStg-1];

  // A triangle without a crossing must deliver all-zero points.
  `TIS_ASSERT_NOW(a_zero_pts, out_valid_o && !has_segment_o,
                  ax_o == '0 && ay_o == '0 && bx_o == '0 && by_o == '0,
                  "crossing points not zero without a segment")
  // A stalled result must hold the input side as well.
  `TIS_ASSERT_NOW(a_stall_back, out_valid_o && out_stall_i, in_stall_o,
                  "input accepted while the result is stalled")
  // Without a stall the pipeline advances every cycle.
  `TIS_ASSERT_NEXT(a_advance, !out_stall_i && in_valid_i,
                   vld_q[0], "accepted triangle did not enter the pipeline")

endmodule

/* verif/triangle_isoline_segment_top_test.sv */
// Testbench for the triangle isoline segment pipeline: directed and random triangles.
module triangle_isoline_segment_top_test;

  // One expected segment, as the block should present it at its output.
  typedef struct {
    logic        has_seg;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] bx;
    logic [31:0] by;
  } segment_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [tis_pkg::CoordW-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  logic signed [tis_pkg::CoordW-1:0] x0_i, y0_i, v0_i, x1_i, y1_i, v1_i, x2_i, y2_i, v2_i;
  logic out_valid_o;
  logic out_stall_i;
  logic has_segment_o;
  logic signed [tis_pkg::CoordW-1:0] ax_o, ay_o, bx_o, by_o;

  // Our own copy of the two contour registers.
  longint level_q;
  longint tol_q;

  segment_t expected_segments[$];
  int unsigned fail_count;
  bit stall_enable;

  triangle_isoline_segment_top dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Crossing point on the edge from p to q, returned as {x, y}.
  function automatic void edge_point(longint px, longint py, longint pv,
                                     longint qx, longint qy, longint qv,
                                     output longint rx, output longint ry);
    longint num, den, ratio, d, prod;
    longint cp[2], cq[2], r[2];
    cp[0] = px; cp[1] = py; cq[0] = qx; cq[1] = qy;
    if (abs64(level_q - pv) < tol_q) begin
      rx = px; ry = py; return;
    end
    if (abs64(level_q - qv) < tol_q) begin
      rx = qx; ry = qy; return;
    end
    if (abs64(pv - qv) < tol_q || pv == qv) begin
      rx = px; ry = py; return;
    end
    num = level_q - pv;
    den = qv - pv;
    ratio = (abs64(num) << 16) / abs64(den);
    if (ratio > 65536) ratio = 65536;
    for (int k = 0; k < 2; k++) begin
      d = cq[k] - cp[k];
      prod = (abs64(d) * ratio) >>> 16;
      r[k] = (d < 0) ? cp[k] - prod : cp[k] + prod;
    end
    rx = r[0];
    ry = r[1];
  endfunction

  function automatic segment_t predict_segment(logic signed [31:0] tri_f[9]);
    segment_t s;
    longint x[3], y[3], v[3], pxs[2], pys[2];
    bit below[3];
    int n;
    int b;
    n = 0;
    pxs = '{0, 0};
    pys = '{0, 0};
    for (int e = 0; e < 3; e++) begin
      x[e] = tri_f[3*e]; y[e] = tri_f[3*e+1]; v[e] = tri_f[3*e+2];
      below[e] = v[e] < level_q;
    end
    for (int e = 0; e < 3; e++) begin
      b = (e == 2) ? 0 : e + 1;
      if (below[e] != below[b] && n < 2) begin
        edge_point(x[e], y[e], v[e], x[b], y[b], v[b], pxs[n], pys[n]);
        n++;
      end
    end
    if (n < 2) begin
      s = '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0};
    end else begin
      s = '{1'b1, pxs[0][31:0], pys[0][31:0], pxs[1][31:0], pys[1][31:0]};
    end
    return s;
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) @(posedge clk_i);
  endtask

  // Sends one triangle and records what should come back for it.
  // Valid stays high after the transfer so that a following triangle can
  // go back to back; it drops only when a gap is drawn.
  task automatic send_triangle(logic signed [31:0] tri_f[9]);
    int gap;
    gap = $urandom_range(0, 14) * ($urandom_range(0, 3) != 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      idle_cycles(gap);
    end
    expected_segments = {expected_segments, predict_segment(tri_f)};
    in_valid_i <= 1'b1;
    x0_i <= tri_f[0]; y0_i <= tri_f[1]; v0_i <= tri_f[2];
    x1_i <= tri_f[3]; y1_i <= tri_f[4]; v1_i <= tri_f[5];
    x2_i <= tri_f[6]; y2_i <= tri_f[7]; v2_i <= tri_f[8];
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Waits for the pipeline to drain, then writes one contour register.
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    in_valid_i <= 1'b0;
    wait (expected_segments.size() == 0);
    idle_cycles(30);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == tis_pkg::CfgIso) level_q = longint'($signed(data));
    else tol_q = longint'(data[15:0]);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 8) - 4;
      default: return $urandom();
    endcase
  endfunction

  // Scalars are drawn near the level so that crossings and ties are common.
  function automatic logic [31:0] rand_scalar();
    longint s;
    if ($urandom_range(0, 4) == 0) return rand_word();
    s = level_q + longint'($signed($urandom_range(0, 2 * 131072))) - 131072;
    if ($urandom_range(0, 3) == 0) s = level_q + $urandom_range(0, 4) - 2;
    return s[31:0];
  endfunction

  task automatic send_random(int n);
    logic signed [31:0] t[9];
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 9; k++) t[k] = ((k % 3) == 2) ? rand_scalar() : rand_word();
      send_triangle(t);
    end
  endtask

  task automatic test_directed();
    // Extreme corners, one vertex below and the others above, then all above and all below.
    send_triangle('{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                    32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                    32'h0, 32'h0, 32'h7fff_ffff});
    send_triangle('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h1_0000, 32'hffff_0000, 32'h0});
    send_triangle('{0, 0, 32'h1_0000, 32'h1_0000, 0, 32'h2_0000,
                    0, 32'h1_0000, 32'h3_0000});
    send_triangle('{0, 0, -32'sh1_0000, 32'h1_0000, 0, -32'sh2_0000,
                    0, 32'h1_0000, -32'sh3_0000});
    // A vertex exactly on the level, and ones just either side of it.
    send_triangle('{0, 0, 0, 32'h4_0000, 0, -32'sh1_0000, 0, 32'h4_0000, 32'h1_0000});
    send_triangle('{5, 7, -1, 32'h4_0000, 3, 32'h2_0000, 9, 32'h4_0000, 1});
    // Each vertex alone below in turn.
    send_triangle('{0, 0, -32'sh1_0000, 32'h8_0000, 0, 32'h3_0000,
                    0, 32'h8_0000, 32'h1_0000});
    send_triangle('{0, 0, 32'h1_0000, 32'h8_0000, 0, -32'sh3_0000,
                    0, 32'h8_0000, 32'h1_0000});
    send_triangle('{0, 0, 32'h1_0000, 32'h8_0000, 0, 32'h3_0000,
                    0, 32'h8_0000, -32'sh1_0000});
  endtask

  task automatic test_wide_tolerance();
    // Tolerance wide enough to hit the near-endpoint and flat-edge cases.
    write_reg(tis_pkg::CfgEps, 32'h0000_ffff);
    write_reg(tis_pkg::CfgIso, 32'h0001_0000);
    send_triangle('{0, 0, 32'h0_8000, 32'h10_0000, 0, 32'h1_8000,
                    0, 32'h10_0000, 32'h0_0000});
    send_triangle('{0, 0, 32'h0_ffff, 32'h10_0000, 0, 32'h1_0001,
                    0, 32'h10_0000, 32'h5_0000});
    send_triangle('{0, 0, -32'sh5_0000, 32'h10_0000, 0, 32'h1_0000,
                    0, 32'h10_0000, 32'h7_0000});
    send_random(150);
  endtask

  task automatic test_zero_tolerance();
    write_reg(tis_pkg::CfgEps, 32'h0);
    write_reg(tis_pkg::CfgIso, 32'h8000_0000);
    send_random(100);
    write_reg(tis_pkg::CfgIso, 32'h7fff_ffff);
    send_random(100);
    write_reg(tis_pkg::CfgIso, 32'hfffe_8000);
    send_random(200);
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 5; p++) begin
      write_reg(tis_pkg::CfgEps, {$urandom_range(0, 1) ? 16'hffff : 16'($urandom_range(0, 300)),
                                  16'($urandom())});
      write_reg(tis_pkg::CfgIso, rand_word());
      send_random(130);
    end
  endtask

  // Output side: stall draws per result, and every transfer is checked.
  initial begin
    int wait_n;
    forever begin
      wait_n = stall_enable ? $urandom_range(0, 14) : 0;
      if (wait_n != 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      if (out_valid_o && rst_ni) begin
        segment_t e;
        if (expected_segments.size() == 0) begin
          $error("result with no triangle outstanding");
          fail_count++;
        end else begin
          e = expected_segments.pop_front();
          if (has_segment_o !== e.has_seg) begin
            $error("has_segment expected %0d got %0d", e.has_seg, has_segment_o); fail_count++;
          end
          if (ax_o !== e.ax) begin
            $error("ax expected %h got %h", e.ax, ax_o); fail_count++;
          end
          if (ay_o !== e.ay) begin
            $error("ay expected %h got %h", e.ay, ay_o); fail_count++;
          end
          if (bx_o !== e.bx) begin
            $error("bx expected %h got %h", e.bx, bx_o); fail_count++;
          end
          if (by_o !== e.by) begin
            $error("by expected %h got %h", e.by, by_o); fail_count++;
          end
        end
      end
    end
  end

  // Safety net against a hung handshake.
  initial begin
    #5000000;
    $display("** triangle_isoline_segment_top: FAILED **");
    $finish;
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0;
    {x0_i, y0_i, v0_i, x1_i, y1_i, v1_i, x2_i, y2_i, v2_i} = '0;
    out_stall_i = 1'b0;
    level_q = 0;
    tol_q = 1;
    fail_count = 0;
    stall_enable = 1'b1;
    idle_cycles(4);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_random(100);
    test_wide_tolerance();
    test_zero_tolerance();
    // A stretch with no stalls at the output, to run the pipe at full rate.
    stall_enable = 1'b0;
    test_random_settings();
    in_valid_i <= 1'b0;
    wait (expected_segments.size() == 0);
    idle_cycles(40);
    if (fail_count == 0) $display("** triangle_isoline_segment_top: PASSED **");
    else $display("** triangle_isoline_segment_top: FAILED **");
    $finish;
  end

endmodule
